### hw/rtl/bwcc_pkg.sv
// Shared types and constants for the binary window count cleaner.
// Used by bwcc_col_mem and binary_window_count_cleaner; depends on nothing.
package bwcc_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int MaxWindow = 15;

  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = $clog2(MaxHeight);
  localparam int HistW    = MaxWindow - 1;
  localparam int SumW     = $clog2(MaxWindow + 1);
  localparam int HalfW    = 3;
  // The row sum grows by at most one column count per pixel and restarts each
  // line, so it must hold a full line of maximum counts.
  localparam int RowSumW  = 14;
  localparam int RecIdxW  = $clog2(MaxWindow);
  localparam int HistIdxW = $clog2(HistW);

  localparam int SideW    = 4;
  localparam int ThrW     = 8;
  localparam int DimW     = 11;
  localparam int CfgDataW = 11;
  localparam int CfgIdxW  = 2;
  localparam int PixW     = 8;
  localparam int PosW     = 10;

  localparam logic [SideW-1:0] SideReset   = 4'd3;
  localparam logic [ThrW-1:0]  ThrReset    = 8'd4;
  localparam logic [DimW-1:0]  WidthReset  = 11'd640;
  localparam logic [DimW-1:0]  HeightReset = 11'd480;
  localparam logic [PixW-1:0]  PixSet      = 8'd255;
  localparam logic [SumW-1:0]  SumSat      = SumW'(MaxWindow - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CfgWindowSide     = 2'd0,
    CfgCountThreshold = 2'd1,
    CfgImageWidth     = 2'd2,
    CfgImageHeight    = 2'd3
  } bwcc_cfg_e;

  typedef struct packed {
    logic [PixW-1:0] pixel_value;
    logic            frame_start;
  } bwcc_in_t;

  typedef struct packed {
    logic [PixW-1:0] clean_value;
    logic [PosW-1:0] out_col;
    logic [PosW-1:0] out_row;
    logic            frame_last;
  } bwcc_out_t;

  // One column entry: recent bit history (newest in bit 0) and partial count.
  typedef struct packed {
    logic [HistW-1:0] hist;
    logic [SumW-1:0]  sum;
  } bwcc_col_entry_t;

  typedef struct packed {
    logic            en;
    logic [ColW-1:0] addr;
    bwcc_col_entry_t data;
  } bwcc_col_wr_t;

endpackage

### hw/rtl/bwcc_col_mem.sv
// Per-column state memory with registered read and write forwarding.
// Depends on bwcc_pkg for the entry and write request types.
module bwcc_col_mem import bwcc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [ColW-1:0] rd_addr_i,
  input  logic            rd_ok_i,
  input  bwcc_col_wr_t    wr_i,
  output bwcc_col_entry_t entry_o
);

  bwcc_col_entry_t mem_q [MaxWidth];
  bwcc_col_entry_t rdata_q;
  bwcc_col_entry_t fwd_data_q;
  logic            fwd_q;
  logic            ok_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rdata_q    <= mem_q[rd_addr_i];
      fwd_data_q <= wr_i.data;
    end
  end

  // A read that meets a write to the same column sees the old data, so the
  // written entry is kept aside and used in its place.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
      ok_q  <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_i.en && (wr_i.addr == rd_addr_i);
      ok_q  <= rd_ok_i;
    end
  end

  // Entries not written since the last frame clear read as zero.
  assign entry_o = !ok_q ? '0 : (fwd_q ? fwd_data_q : rdata_q);

endmodule

### hw/rtl/binary_window_count_cleaner.sv
// Binary window count cleaner: one pixel per cycle; results pass stage B into an output queue.
// Throughput is one request per clock while the output queue has room, set by the single
// read-modify-write of the column memory (read on accept, write back the next cycle with forwarding).
// Reset (async, active low) restores default registers and clears position and
// fill count; the column memory is not swept, a fill count masks stale entries.
module binary_window_count_cleaner import bwcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bwcc_in_t            in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bwcc_out_t           out_req_o
);

  typedef struct packed {
    logic [ColW-1:0]  col;
    logic             bit_set;
    logic [HalfW-1:0] half;
    logic             row_clr;
    logic             emit;
    logic             border_ok;
    logic [PosW-1:0]  cx;
    logic [PosW-1:0]  cy;
    logic             last;
  } stage_b_t;

  logic [SideW-1:0] side_q;
  logic [ThrW-1:0]  thr_q;
  logic [DimW-1:0]  width_q;
  logic [DimW-1:0]  height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q   <= SideReset;
      thr_q    <= ThrReset;
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (bwcc_cfg_e'(cfg_idx_i))
        CfgWindowSide:     side_q   <= cfg_wdata_i[SideW-1:0];
        CfgCountThreshold: thr_q    <= cfg_wdata_i[ThrW-1:0];
        CfgImageWidth:     width_q  <= cfg_wdata_i[DimW-1:0];
        CfgImageHeight:    height_q <= cfg_wdata_i[DimW-1:0];
        default:           side_q   <= side_q;
      endcase
    end
  end

  // ---------------- Stage A: position tracking and memory read ----------------
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW:0]   fill_q, fill_d;
  logic            b_valid_q;
  stage_b_t        b_q, b_d;
  logic            in_acc;

  logic [HalfW-1:0] half_raw, half_eff;
  logic [DimW-1:0]  w_eff, h_eff;
  logic             frame_clr;
  logic [ColW-1:0]  a_col;
  logic [RowW-1:0]  a_row;
  logic [ColW:0]    a_fill, col_inc, fill_new;
  logic [RowW:0]    row_inc;
  logic             ent_ok;

  always_comb begin
    half_raw = side_q[SideW-1:1];
    half_eff = ({half_raw, 1'b1} > 4'(MaxWindow)) ? HalfW'((MaxWindow - 1) / 2) : half_raw;

    if (width_q == '0) begin
      w_eff = DimW'(1);
    end else if (width_q > DimW'(MaxWidth)) begin
      w_eff = DimW'(MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DimW'(1);
    end else if (height_q > DimW'(MaxHeight)) begin
      h_eff = DimW'(MaxHeight);
    end else begin
      h_eff = height_q;
    end

    // A position outside the frame is treated like a frame start.
    frame_clr = in_req_i.frame_start || (DimW'(col_q) >= w_eff) || (DimW'(row_q) >= h_eff);
    a_col     = frame_clr ? '0 : col_q;
    a_row     = frame_clr ? '0 : row_q;
    a_fill    = frame_clr ? '0 : fill_q;
    ent_ok    = {1'b0, a_col} < a_fill;
    col_inc   = {1'b0, a_col} + (ColW+1)'(1);
    row_inc   = {1'b0, a_row} + (RowW+1)'(1);
    fill_new  = (col_inc > a_fill) ? col_inc : a_fill;

    b_d.col       = a_col;
    b_d.bit_set   = in_req_i.pixel_value != '0;
    b_d.half      = half_eff;
    b_d.row_clr   = a_col == '0;
    b_d.emit      = (a_col >= ColW'(half_eff)) && (a_row >= RowW'(half_eff));
    b_d.cx        = PosW'(a_col - ColW'(half_eff));
    b_d.cy        = PosW'(a_row - RowW'(half_eff));
    b_d.border_ok = (b_d.cx >= PosW'(half_eff)) && (b_d.cy >= PosW'(half_eff));
    b_d.last      = (DimW'(a_col) == w_eff - DimW'(1)) && (DimW'(a_row) == h_eff - DimW'(1));

    if (DimW'(col_inc) >= w_eff) begin
      col_d = '0;
      if (DimW'(row_inc) >= h_eff) begin
        row_d  = '0;
        fill_d = '0;
      end else begin
        row_d  = row_inc[RowW-1:0];
        fill_d = fill_new;
      end
    end else begin
      col_d  = col_inc[ColW-1:0];
      row_d  = a_row;
      fill_d = fill_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      fill_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= in_acc;
      if (in_acc) begin
        col_q  <= col_d;
        row_q  <= row_d;
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      b_q <= b_d;
    end
  end

  // ---------------- Column memory ----------------
  bwcc_col_wr_t    col_wr;
  bwcc_col_entry_t col_ent;

  bwcc_col_mem u_col_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (a_col),
    .rd_ok_i   (ent_ok),
    .wr_i      (col_wr),
    .entry_o   (col_ent)
  );

  // ---------------- Stage B: column update and horizontal window ----------------
  logic [SumW-1:0]    recent_q [MaxWindow];
  logic [SumW-1:0]    recent_base [MaxWindow];
  logic [RowSumW-1:0] rowsum_q, rowsum_base, rowsum_new;
  logic [SumW:0]      full, part_raw;
  logic               dropped;
  logic [SumW-1:0]    part, leave;
  logic [RowSumW:0]   acc;
  bwcc_out_t          res;

  always_comb begin
    full    = {1'b0, col_ent.sum} + (SumW+1)'(b_q.bit_set);
    dropped = 1'b0;
    if (b_q.half != '0) begin
      dropped = col_ent.hist[HistIdxW'({b_q.half, 1'b0}) - HistIdxW'(1)];
    end
    part_raw = (full >= (SumW+1)'(dropped)) ? full - (SumW+1)'(dropped) : '0;
    if (b_q.half == '0) begin
      part = '0;
    end else if (part_raw > (SumW+1)'(SumSat)) begin
      part = SumSat;
    end else begin
      part = part_raw[SumW-1:0];
    end

    col_wr.en        = b_valid_q;
    col_wr.addr      = b_q.col;
    col_wr.data.hist = {col_ent.hist[HistW-2:0], b_q.bit_set};
    col_wr.data.sum  = part;

    // A new row starts its horizontal window from empty.
    for (int i = 0; i < MaxWindow; i++) begin
      recent_base[i] = b_q.row_clr ? '0 : recent_q[i];
    end
    rowsum_base = b_q.row_clr ? '0 : rowsum_q;
    leave       = recent_base[RecIdxW'({b_q.half, 1'b0})];
    acc         = {1'b0, rowsum_base} + (RowSumW+1)'(full);
    rowsum_new  = (acc >= (RowSumW+1)'(leave)) ? RowSumW'(acc - (RowSumW+1)'(leave)) : '0;

    res.clean_value = (b_q.border_ok && (rowsum_new > RowSumW'(thr_q))) ? PixSet : '0;
    res.out_col     = b_q.cx;
    res.out_row     = b_q.cy;
    res.frame_last  = b_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxWindow; i++) begin
        recent_q[i] <= '0;
      end
      rowsum_q <= '0;
    end else if (b_valid_q) begin
      recent_q[0] <= full[SumW-1:0];
      for (int i = 1; i < MaxWindow; i++) begin
        recent_q[i] <= recent_base[i-1];
      end
      rowsum_q <= rowsum_new;
    end
  end

  // ---------------- Output queue ----------------
  bwcc_out_t  fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  logic [2:0] occ;

  assign push        = b_valid_q && b_q.emit;
  assign out_valid_o = cnt_q != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_req_o   = fifo_q[rd_ptr_q];
  // Room is reserved for the request in stage B whether or not it emits.
  assign occ         = 3'(cnt_q) + 3'(b_valid_q) - 3'(pop);
  assign in_ready_o  = occ <= 3'd1;
  assign in_acc      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("output queue holds more than two results");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |-> (cnt_q < 2'd2))
    else $error("result pushed into a full output queue");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (ColW+1)'(MaxWidth))
    else $error("column fill count beyond memory depth");

endmodule

### dv/tb_top.sv
// Testbench for binary_window_count_cleaner: raster frames of varied size and content
// are checked against a window-count predictor kept in a small scoreboard class.
// Depends on bwcc_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_top;
  import bwcc_pkg::*;

  class clean_scoreboard;
    logic [SideW-1:0] side_reg;
    logic [ThrW-1:0]  thr_reg;
    logic [DimW-1:0]  width_reg;
    logic [DimW-1:0]  height_reg;
    logic [HistW-1:0] col_hist [MaxWidth];
    int unsigned      col_part [MaxWidth];
    int unsigned      run_sums [MaxWindow];
    int unsigned      window_sum;
    int unsigned      cur_col;
    int unsigned      cur_row;
    bwcc_out_t        expected_pixels [$];
    int               errors;

    function new();
      errors     = 0;
      side_reg   = SideReset;
      thr_reg    = ThrReset;
      width_reg  = WidthReset;
      height_reg = HeightReset;
      clear_frame();
    endfunction

    function void clear_row();
      foreach (run_sums[i]) run_sums[i] = 0;
      window_sum = 0;
    endfunction

    function void clear_frame();
      foreach (col_hist[i]) begin
        col_hist[i] = '0;
        col_part[i] = 0;
      end
      clear_row();
      cur_col = 0;
      cur_row = 0;
    endfunction

    function int unsigned half_eff();
      int unsigned h = side_reg / 2;
      if (2 * h + 1 > MaxWindow) h = (MaxWindow - 1) / 2;
      return h;
    endfunction

    function int unsigned width_eff();
      if (width_reg == 0) return 1;
      if (width_reg > MaxWidth) return MaxWidth;
      return width_reg;
    endfunction

    function int unsigned height_eff();
      if (height_reg == 0) return 1;
      if (height_reg > MaxHeight) return MaxHeight;
      return height_reg;
    endfunction

    function int unsigned frame_size();
      return width_eff() * height_eff();
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function void write_reg(bwcc_cfg_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgWindowSide:     side_reg   = data[SideW-1:0];
        CfgCountThreshold: thr_reg    = data[ThrW-1:0];
        CfgImageWidth:     width_reg  = data[DimW-1:0];
        CfgImageHeight:    height_reg = data[DimW-1:0];
        default: ;
      endcase
    endfunction

    // Advances the window state by one accepted pixel and queues the result it causes.
    function void note_pixel(bwcc_in_t px);
      int unsigned      h, w, ht, full, part, leave, cx, cy;
      logic             b;
      logic [HistW-1:0] hist;
      bwcc_out_t        want;
      h  = half_eff();
      w  = width_eff();
      ht = height_eff();
      if (px.frame_start || cur_col >= w || cur_row >= ht) clear_frame();
      if (cur_col == 0) clear_row();

      b    = (px.pixel_value != '0);
      hist = col_hist[cur_col];
      full = col_part[cur_col] + b;
      if (h > 0) begin
        // The partial count drops the bit that leaves the window next row.
        part = (full >= hist[2 * h - 1]) ? full - hist[2 * h - 1] : 0;
        if (part > MaxWindow - 1) part = MaxWindow - 1;
      end else begin
        part = 0;
      end
      col_hist[cur_col] = {hist[HistW-2:0], b};
      col_part[cur_col] = part;

      leave = run_sums[2 * h];
      for (int i = MaxWindow - 1; i > 0; i--) run_sums[i] = run_sums[i - 1];
      run_sums[0] = full;
      window_sum = (window_sum + full >= leave) ? window_sum + full - leave : 0;

      if (cur_col >= h && cur_row >= h) begin
        cx = cur_col - h;
        cy = cur_row - h;
        want.clean_value = (cx >= h && cy >= h && window_sum > thr_reg) ? PixSet : '0;
        want.out_col     = cx[PosW-1:0];
        want.out_row     = cy[PosW-1:0];
        want.frame_last  = (cur_col == w - 1 && cur_row == ht - 1);
        expected_pixels.push_back(want);
      end

      cur_col++;
      if (cur_col >= w) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= ht) clear_frame();
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("MISMATCH: %s", what);
    endtask

    task check_result(bwcc_out_t got);
      bwcc_out_t want;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result at (%0d,%0d)", got.out_col, got.out_row));
        return;
      end
      want = expected_pixels.pop_front();
      if (got.clean_value !== want.clean_value)
        report_mismatch($sformatf("clean_value at (%0d,%0d): got %0d, want %0d",
                                  want.out_col, want.out_row, got.clean_value,
                                  want.clean_value));
      if (got.out_col !== want.out_col)
        report_mismatch($sformatf("out_col: got %0d, want %0d", got.out_col, want.out_col));
      if (got.out_row !== want.out_row)
        report_mismatch($sformatf("out_row: got %0d, want %0d", got.out_row, want.out_row));
      if (got.frame_last !== want.frame_last)
        report_mismatch($sformatf("frame_last at (%0d,%0d): got %0b, want %0b",
                                  want.out_col, want.out_row, got.frame_last,
                                  want.frame_last));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  bwcc_in_t            in_req_i;
  logic                out_valid_o;
  logic                out_ready_i;
  bwcc_out_t           out_req_o;

  clean_scoreboard board;
  int              snd_idle_pct;
  int              rcv_idle_pct;

  binary_window_count_cleaner uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_req_o   (out_req_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_pixel(in_req_i);
      if (out_valid_o && out_ready_i) board.check_result(out_req_o);
    end
  end

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic push_pixel(input bwcc_in_t px);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= px;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // A pixel may cause no result, so the task keeps waiting once the expected queue is empty.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(input bwcc_cfg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    board.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic config_all(input logic [CfgDataW-1:0] side_d, input logic [CfgDataW-1:0] thr_d,
                            input logic [CfgDataW-1:0] wid_d, input logic [CfgDataW-1:0] hgt_d);
    cfg_write(CfgWindowSide, side_d);
    cfg_write(CfgCountThreshold, thr_d);
    cfg_write(CfgImageWidth, wid_d);
    cfg_write(CfgImageHeight, hgt_d);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned count, input int dens, input bit lead_start,
                            input int stray_pct);
    bwcc_in_t px;
    for (int unsigned i = 0; i < count; i++) begin
      px.frame_start = (lead_start && i == 0) || ($urandom_range(99) < stray_pct);
      px.pixel_value = ($urandom_range(99) < dens) ? PixW'($urandom_range(255, 1)) : '0;
      push_pixel(px);
      if ($urandom_range(399) == 0) wait_drained();
    end
  endtask

  // Sizes stay near the window so that most frames finish and borders are reached.
  task automatic random_config();
    int unsigned         side_v, span;
    logic [CfgDataW-1:0] wid_v, hgt_v, thr_v;
    side_v = $urandom_range(15);
    span   = 2 * (side_v / 2) + 1;
    wid_v  = ($urandom_range(9) == 0) ? CfgDataW'($urandom_range(1) ? 2047 : 0)
                                      : CfgDataW'($urandom_range(span + 8, 1));
    hgt_v  = ($urandom_range(9) == 0) ? CfgDataW'($urandom_range(1) ? 2047 : 0)
                                      : CfgDataW'($urandom_range(span + 8, 1));
    thr_v  = ($urandom_range(4) == 0) ? CfgDataW'($urandom_range(255))
                                      : CfgDataW'($urandom_range(span * span));
    // Bits above each register's width are written too and must be ignored.
    thr_v[CfgDataW-1:ThrW] = (CfgDataW-ThrW)'($urandom);
    config_all({7'($urandom), 4'(side_v)}, thr_v, wid_v, hgt_v);
  endtask

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int          small_items;
    int          budget;
    int          sent;
    int unsigned n;
    board        = new();
    snd_idle_pct = 18;
    rcv_idle_pct = 75;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CfgWindowSide;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_req_i     = '0;
    out_ready_i  = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Window of one pixel on 1x1 frames: every pixel ends its own frame.
    config_all(11'd0, 11'd0, 11'd0, 11'd0);
    push_pixel('{8'd0, 1'b1});
    push_pixel('{8'd1, 1'b0});
    push_pixel('{8'd128, 1'b0});
    push_pixel('{8'd255, 1'b0});
    wait_drained();
    // A full 3x3 window over a 3x3 image sets only the centre.
    config_all(11'd2, 11'd8, 11'd3, 11'd3);
    send_frame(9, 100, 1'b1, 0);
    wait_drained();
    // Widest window with oversized dimensions: nothing is emitted yet.
    config_all(11'd15, 11'd255, 11'd2047, 11'd2047);
    send_frame(4, 50, 1'b1, 0);
    wait_drained();
    // Shrinking the width leaves the position outside the frame.
    config_all(11'd0, 11'd255, 11'd2, 11'd3);
    send_frame(3, 100, 1'b0, 0);

    small_items = 0;
    while (small_items < 360) begin
      if (small_items < 120) begin
        snd_idle_pct = 18;
        rcv_idle_pct = 75;
      end else if (small_items < 240) begin
        snd_idle_pct = 75;
        rcv_idle_pct = 18;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      wait_drained();
      random_config();
      budget = $urandom_range(160, 40);
      sent   = 0;
      while (sent < budget) begin
        if ($urandom_range(99) < 75) begin
          n = board.frame_size();
          if (n > 400) n = 400;
          if ($urandom_range(9) == 0) n = $urandom_range(n, 1);
          send_frame(n, $urandom_range(2) * 45 + 5, $urandom_range(7) != 0, 0);
        end else begin
          n = $urandom_range(10, 1);
          send_frame(n, 50, 1'b0, 15);
        end
        sent        += n;
        small_items += n;
      end
    end

    // One full line at the widest width, wrapping to a new frame at its end.
    wait_drained();
    config_all(11'd1, 11'd0, 11'd2047, 11'd1);
    send_frame(1027, 50, 1'b1, 0);

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
